// ===== hw/rtl/mtd_pkg.sv =====
// mtd_pkg: constants, types and the symbol decode table for the morse text decoder
// no dependencies; imported by morse_text_decoder_core and its checker
`default_nettype none

package mtd_pkg;

    // longest symbol kept in the element store
    localparam int MAX_CODE_LENGTH = 5;

    // text bytes that matter on the input side
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    typedef logic [MAX_CODE_LENGTH-1:0] sym_bits_t;
    typedef logic [2:0]                 count3_t;

    // saturation point of the element and space counters
    localparam count3_t COUNT_SAT       = 3'd7;
    // run length that separates symbols without emitting a space
    localparam count3_t SPACE_RUN_GAP   = 3'd3;
    // longest symbol the decode table holds
    localparam count3_t TABLE_MAX_LEN   = 3'd5;

    // decode table: element i at bit i, dash = 1; unknown or empty gives 0
    function automatic logic [7:0] decode_symbol(input sym_bits_t bits, input count3_t len);
        logic [7:0] ch;
        logic [4:0] b;
        ch = CHAR_NONE;
        b  = bits[4:0];
        if (len != 3'd0 && len <= TABLE_MAX_LEN)
        begin
            unique case ({len, b})
                {3'd1, 5'b00000}: ch = "E";
                {3'd1, 5'b00001}: ch = "T";
                {3'd2, 5'b00010}: ch = "A";
                {3'd2, 5'b00000}: ch = "I";
                {3'd2, 5'b00011}: ch = "M";
                {3'd2, 5'b00001}: ch = "N";
                {3'd3, 5'b00001}: ch = "D";
                {3'd3, 5'b00011}: ch = "G";
                {3'd3, 5'b00101}: ch = "K";
                {3'd3, 5'b00111}: ch = "O";
                {3'd3, 5'b00010}: ch = "R";
                {3'd3, 5'b00000}: ch = "S";
                {3'd3, 5'b00100}: ch = "U";
                {3'd3, 5'b00110}: ch = "W";
                {3'd4, 5'b00001}: ch = "B";
                {3'd4, 5'b00101}: ch = "C";
                {3'd4, 5'b00100}: ch = "F";
                {3'd4, 5'b00000}: ch = "H";
                {3'd4, 5'b01110}: ch = "J";
                {3'd4, 5'b00010}: ch = "L";
                {3'd4, 5'b00110}: ch = "P";
                {3'd4, 5'b01011}: ch = "Q";
                {3'd4, 5'b01000}: ch = "V";
                {3'd4, 5'b01001}: ch = "X";
                {3'd4, 5'b01101}: ch = "Y";
                {3'd4, 5'b00011}: ch = "Z";
                {3'd5, 5'b11111}: ch = "0";
                {3'd5, 5'b11110}: ch = "1";
                {3'd5, 5'b11100}: ch = "2";
                {3'd5, 5'b11000}: ch = "3";
                {3'd5, 5'b10000}: ch = "4";
                {3'd5, 5'b00000}: ch = "5";
                {3'd5, 5'b00001}: ch = "6";
                {3'd5, 5'b00011}: ch = "7";
                {3'd5, 5'b00111}: ch = "8";
                {3'd5, 5'b01111}: ch = "9";
                default:          ch = CHAR_NONE;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/morse_text_decoder_core.sv =====
// morse_text_decoder_core: turns a stream of dot/dash/space/newline bytes into text
// depends on mtd_pkg (constants, decode table)
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   input   | in        | in_valid / in_stall  | char_in, next_char
//   output  | out       | out_valid / out_stall| out_char, last
//
// unstalled, one byte enters the input register per cycle; decode and state update
// sit between that register and the result register, so one transaction a cycle flows
// a newline gives two results; bytes that give a result wait on the input side while
// the newline sits in the one-entry newline slot behind the single result register
// bytes that give no result retire even while the output is stalled
// rst_n clears the symbol store, the space counter and all valid flags
`default_nettype none

module morse_text_decoder_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic [7:0]           char_in,
    input  wire logic [7:0]           next_char,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic [7:0]           out_char,
    output      logic                 last
);
    import mtd_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic [7:0] peek_reg;

    // decoder state
    sym_bits_t  sym_bits_reg, sym_bits_next;
    count3_t    sym_len_reg, sym_len_next;
    count3_t    space_cnt_reg, space_cnt_next;

    // result register and pending newline slot
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       last_reg, last_next;
    logic       nl_pend_reg, nl_pend_next;

    // per-item decode
    logic       is_nl, is_elem, is_space, peek_space;
    sym_bits_t  bits_upd;
    count3_t    len_upd, cnt_upd;
    logic       emit, proc, out_take, out_free, in_take;
    logic [7:0] res_char;

    always_comb
    begin
        is_nl      = (char_reg == CHAR_NEWLINE);
        is_elem    = (char_reg == CHAR_DOT) || (char_reg == CHAR_DASH);
        is_space   = (char_reg == CHAR_SPACE);
        peek_space = (peek_reg == CHAR_SPACE);

        // append the element to the symbol store
        bits_upd = sym_bits_reg;
        if (char_reg == CHAR_DASH && sym_len_reg < count3_t'(MAX_CODE_LENGTH))
        begin
            bits_upd[sym_len_reg] = 1'b1;
        end
        len_upd = (sym_len_reg < COUNT_SAT) ? 3'(sym_len_reg + 3'd1) : sym_len_reg;
        cnt_upd = (space_cnt_reg < COUNT_SAT) ? 3'(space_cnt_reg + 3'd1) : space_cnt_reg;

        // result and next state for the held byte
        sym_bits_next  = sym_bits_reg;
        sym_len_next   = sym_len_reg;
        space_cnt_next = space_cnt_reg;
        emit           = 1'b0;
        res_char       = CHAR_NONE;
        if (is_nl)
        begin
            emit          = 1'b1;
            res_char      = decode_symbol(sym_bits_reg, sym_len_reg);
            sym_bits_next = '0;
            sym_len_next  = '0;
        end
        else if (is_elem)
        begin
            if (peek_space)
            begin
                emit          = 1'b1;
                res_char      = decode_symbol(bits_upd, len_upd);
                sym_bits_next = '0;
                sym_len_next  = '0;
            end
            else
            begin
                sym_bits_next = bits_upd;
                sym_len_next  = len_upd;
            end
        end
        else if (is_space)
        begin
            space_cnt_next = cnt_upd;
            if (!peek_space && cnt_upd >= SPACE_RUN_GAP)
            begin
                space_cnt_next = '0;
                if (cnt_upd != SPACE_RUN_GAP)
                begin
                    emit     = 1'b1;
                    res_char = CHAR_SPACE;
                end
            end
        end

        // handshake between the stages
        out_take = out_valid_reg && !out_stall;
        out_free = !nl_pend_reg && (!out_valid_reg || !out_stall);
        proc     = in_valid_reg && (!emit || out_free);
        in_stall = in_valid_reg && !proc;
        in_take  = in_valid && !in_stall;
        in_valid_next = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_reg);

        // result register loading
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        nl_pend_next   = nl_pend_reg;
        if (proc && emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = res_char;
            last_next      = !is_nl;
            nl_pend_next   = is_nl;
        end
        else if (out_take)
        begin
            if (nl_pend_reg)
            begin
                out_char_next = CHAR_NEWLINE;
                last_next     = 1'b1;
                nl_pend_next  = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            nl_pend_reg   <= 1'b0;
            sym_bits_reg  <= '0;
            sym_len_reg   <= '0;
            space_cnt_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            nl_pend_reg   <= nl_pend_next;
            if (proc)
            begin
                sym_bits_reg  <= sym_bits_next;
                sym_len_reg   <= sym_len_next;
                space_cnt_reg <= space_cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_in;
            peek_reg <= next_char;
        end
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mtd_checker.sv =====
// mtd_checker: port-level assertions for morse_text_decoder_core, bound to that module
// depends on mtd_pkg (character constants)
`default_nettype none

module mtd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_char,
    input wire logic       last
);
    import mtd_pkg::*;

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
        else $error("stalled result changed");

    // a non-final result is always followed by the newline that closes it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && out_char == CHAR_NEWLINE && last)
        else $error("newline did not follow its decoded symbol");

    // newline and space results are always the final result of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == CHAR_NEWLINE || out_char == CHAR_SPACE) |-> last)
        else $error("newline or space without last");

    // the input side is never stalled while idle on both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_valid) && !$past(out_valid) |-> !in_stall)
        else $error("input stalled with nothing in flight");

endmodule

bind morse_text_decoder_core mtd_checker u_mtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
);

`default_nettype wire
